/* rtl/arma_garch_likelihood_filter_macros.svh */
// ----------------------------------------------------------------------------
// arma_garch_likelihood_filter_macros
// Assertion helpers for the filter RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clock and reset in scope.
`ifndef ARMA_GARCH_LIKELIHOOD_FILTER_MACROS_SVH
`define ARMA_GARCH_LIKELIHOOD_FILTER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AGF_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("agf: invariant violated");

// Same-cycle implication.
`define AGF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("agf: implication violated");

`endif

/* rtl/agf_pkg.sv */
// ----------------------------------------------------------------------------
// agf_pkg
// Types, constants and helpers shared by the ARMA-GARCH likelihood filter.
// ----------------------------------------------------------------------------
package agf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_BITS = 16;
   localparam int COUNT_W   = 24;
   localparam int E2_W      = 63 - FRAC_BITS;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last_in;
   } agf_req_type;

   typedef struct packed {
      logic signed [31:0] residual;
      logic [31:0]        variance;
      logic signed [31:0] nll_term;
      logic signed [31:0] mean_nll;
      logic               failed;
      logic               last_out;
   } agf_rsp_type;

   typedef struct packed {
      logic signed [31:0] mean_offset;
      logic signed [31:0] ar_coeff;
      logic signed [31:0] ma_coeff;
      logic [31:0]        var_const;
      logic [15:0]        arch_coeff;
      logic [15:0]        garch_coeff;
      logic [31:0]        initial_variance;
      logic [31:0]        variance_floor;
   } agf_cfg_type;

   typedef enum logic [2:0] {
      CSR_MEAN_OFFSET,
      CSR_AR_COEFF,
      CSR_MA_COEFF,
      CSR_VAR_CONST,
      CSR_ARCH_COEFF,
      CSR_GARCH_COEFF,
      CSR_INITIAL_VARIANCE,
      CSR_VARIANCE_FLOOR
   } agf_csr_type;

   // One classified observation handed from the recursion to the likelihood side
   typedef struct packed {
      logic signed [31:0]  residual;
      logic [31:0]         variance;
      logic                failed;
      logic                last;
      logic                add;
      logic                cond;
      logic [COUNT_W-1:0]  count;
   } agf_item_type;

   typedef enum logic [2:0] {
      F_IDLE, F_AR, F_MA, F_ESQ, F_E2, F_AHI, F_ALO, F_FIN
   } agf_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_ESQ, B_NUM, B_DIV, B_NORM, B_SQMUL, B_SQADJ, B_LNA, B_LNB,
      B_LNC, B_ACC, B_MEAN, B_MDIV, B_MFIN, B_OUT
   } agf_back_state_type;

   function automatic logic signed [31:0] agf_sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

/* rtl/arma_garch_likelihood_filter.sv */
// ----------------------------------------------------------------------------
// arma_garch_likelihood_filter
// ARMA(1,1)-GARCH(1,1) Gaussian negative log-likelihood filter, Q16.16.
// ----------------------------------------------------------------------------
// The recursion front end takes one observation at a time and stalls requests
// until it has handed that observation to the queue; its six passes go through
// a single 33x33 multiplier, and the conditioning item of a series skips them.
// For each likelihood term the back end runs a bit-serial divide for e*e/h,
// then normalization and mantissa squaring for ln h; the last item of a
// series adds a mean divide. Conditioning and failed items skip the back-end
// arithmetic. A two-entry queue sits between the two sides, so sustained
// throughput follows the back end. Write the registers only while no
// transaction is in flight.
module arma_garch_likelihood_filter #(
   parameter int MAX_SERIES_LEN = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  agf_pkg::agf_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output agf_pkg::agf_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import agf_pkg::*;

   agf_cfg_type  cfg_ff;
   agf_item_type f_item, q_head;
   logic         q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_offset      <= '0;
         cfg_ff.ar_coeff         <= '0;
         cfg_ff.ma_coeff         <= '0;
         cfg_ff.var_const        <= 32'd65536;
         cfg_ff.arch_coeff       <= '0;
         cfg_ff.garch_coeff      <= '0;
         cfg_ff.initial_variance <= 32'd65536;
         cfg_ff.variance_floor   <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (agf_csr_type'(csr_index))
            CSR_MEAN_OFFSET:      cfg_ff.mean_offset      <= csr_data;
            CSR_AR_COEFF:         cfg_ff.ar_coeff         <= csr_data;
            CSR_MA_COEFF:         cfg_ff.ma_coeff         <= csr_data;
            CSR_VAR_CONST:        cfg_ff.var_const        <= csr_data;
            CSR_ARCH_COEFF:       cfg_ff.arch_coeff       <= csr_data[15:0];
            CSR_GARCH_COEFF:      cfg_ff.garch_coeff      <= csr_data[15:0];
            CSR_INITIAL_VARIANCE: cfg_ff.initial_variance <= csr_data;
            CSR_VARIANCE_FLOOR:   cfg_ff.variance_floor   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   agf_front #(
      .MAX_SERIES_LEN(MAX_SERIES_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_item    (f_item),
      .q_full    (q_full)
   );

   agf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_head),
      .empty     (q_empty)
   );

   agf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/agf_front.sv */
// ----------------------------------------------------------------------------
// agf_front
// ARMA residual and GARCH variance recursion on one shared multiplier,
// classifies each observation and hands it to the queue.
// ----------------------------------------------------------------------------
module agf_front #(
   parameter int MAX_SERIES_LEN = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  agf_pkg::agf_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  agf_pkg::agf_req_type req_data,
   output logic                 q_push,
   output agf_pkg::agf_item_type q_item,
   input  logic                 q_full
);
   import agf_pkg::*;

   localparam int CW = $clog2(MAX_SERIES_LEN);

   agf_front_state_type state_ff, state_in;

   logic signed [31:0] samp_ff;
   logic               last_ff;
   logic signed [31:0] prev_sample_ff;
   logic signed [31:0] prev_res_ff;
   logic [31:0]        prev_var_ff;
   logic [CW-1:0]      count_ff;
   logic               in_series_ff;
   logic               fail_seen_ff;
   logic signed [65:0] prod_ff;
   logic signed [49:0] acc_ff;
   logic [E2_W-1:0]    e2_ff;
   logic [48:0]        hsum_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [65:0] rnd_full;
   logic signed [32:0] ep_ext, ea;
   logic [63:0]        e2_full;
   logic [48:0]        hi_rnd, hfin;
   logic [16:0]        coef_sum;
   logic               bad, sat, fail_now, add_now, accept;
   logic [31:0]        var_now;
   logic [CW-1:0]      count_next;
   logic signed [31:0] res_now;

   // Select multiplier operands by step
   assign ep_ext = 33'(prev_res_ff);
   assign ea     = ep_ext[32] ? -ep_ext : ep_ext;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         F_AR: begin
            mul_a = 33'(cfg.ar_coeff);
            mul_b = 33'(prev_sample_ff);
         end
         F_MA: begin
            mul_a = 33'(cfg.ma_coeff);
            mul_b = ep_ext;
         end
         F_ESQ: begin
            mul_a = ea;
            mul_b = ea;
         end
         F_E2: begin
            mul_a = $signed({17'b0, cfg.garch_coeff});
            mul_b = $signed({1'b0, prev_var_ff});
         end
         F_AHI: begin
            mul_a = $signed({17'b0, cfg.arch_coeff});
            mul_b = $signed(33'(e2_ff[E2_W-1:COEF_BITS]));
         end
         F_ALO: begin
            mul_a = $signed({17'b0, cfg.arch_coeff});
            mul_b = $signed({17'b0, e2_ff[COEF_BITS-1:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign rnd_full = (prod_ff + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign e2_full  = (prod_ff[63:0] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   assign hi_rnd   = 49'((prod_ff[48:0] + 49'h8000) >> COEF_BITS);
   assign hfin     = hsum_ff + hi_rnd;

   // Classify the finished observation
   assign coef_sum   = {1'b0, cfg.arch_coeff} + {1'b0, cfg.garch_coeff};
   assign bad        = (cfg.var_const == 32'd0) || coef_sum[16];
   assign sat        = hfin > 49'h0FFFFFFFF;
   assign var_now    = sat ? 32'hFFFFFFFF : hfin[31:0];
   assign res_now    = agf_sat32(64'(acc_ff));
   assign fail_now   = fail_seen_ff || sat || bad || (var_now < cfg.variance_floor) ||
                       (count_ff >= CW'(MAX_SERIES_LEN - 1));
   assign add_now    = !fail_now;
   assign count_next = count_ff + CW'(add_now);

   always_comb begin
      q_item = '0;
      if (!in_series_ff) begin
         q_item.residual = '0;
         q_item.variance = cfg.initial_variance;
         q_item.failed   = bad || (cfg.initial_variance < cfg.variance_floor) || last_ff;
         q_item.last     = last_ff;
         q_item.add      = 1'b0;
         q_item.cond     = 1'b1;
         q_item.count    = '0;
      end else begin
         q_item.residual = res_now;
         q_item.variance = var_now;
         q_item.failed   = fail_now;
         q_item.last     = last_ff;
         q_item.add      = add_now;
         q_item.cond     = 1'b0;
         q_item.count    = COUNT_W'(count_next);
      end
   end

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;
   assign q_push    = (state_ff == F_FIN) && !q_full;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: conditioning items skip the arithmetic
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) begin
            state_in = in_series_ff ? F_AR : F_FIN;
         end
         F_AR:   state_in = F_MA;
         F_MA:   state_in = F_ESQ;
         F_ESQ:  state_in = F_E2;
         F_E2:   state_in = F_AHI;
         F_AHI:  state_in = F_ALO;
         F_ALO:  state_in = F_FIN;
         F_FIN: if (!q_full) begin
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Datapath registers; hold the last product while waiting on the queue
   always_ff @(posedge clock) begin
      if (state_ff != F_FIN) begin
         prod_ff <= mul_p;
      end
      case (state_ff)
         F_IDLE: if (accept) begin
            samp_ff <= req_data.sample;
            last_ff <= req_data.last_in;
         end
         F_MA:  acc_ff  <= 50'(samp_ff) - 50'(cfg.mean_offset) - rnd_full[49:0];
         F_ESQ: acc_ff  <= acc_ff - rnd_full[49:0];
         F_E2:  e2_ff   <= e2_full[E2_W-1:0];
         F_AHI: hsum_ff <= 49'(cfg.var_const) + hi_rnd;
         F_ALO: hsum_ff <= hsum_ff + prod_ff[48:0];
         default: begin
         end
      endcase
   end

   // Recursion state: advance when the transaction leaves for the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= '0;
         prev_res_ff    <= '0;
         prev_var_ff    <= '0;
         count_ff       <= '0;
         in_series_ff   <= 1'b0;
         fail_seen_ff   <= 1'b0;
      end else if (q_push) begin
         prev_sample_ff <= samp_ff;
         prev_res_ff    <= q_item.residual;
         prev_var_ff    <= q_item.variance;
         count_ff       <= in_series_ff ? count_next : '0;
         fail_seen_ff   <= q_item.failed;
         in_series_ff   <= !last_ff;
      end
   end

endmodule

/* rtl/agf_queue.sv */
// ----------------------------------------------------------------------------
// agf_queue
// Two-entry queue that decouples the recursion from the likelihood back end.
// ----------------------------------------------------------------------------
module agf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  agf_pkg::agf_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output agf_pkg::agf_item_type pop_item,
   output logic                  empty
);
   import agf_pkg::*;

   agf_item_type mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   fill_ff;

   assign full     = fill_ff[1];
   assign empty    = (fill_ff == 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* rtl/agf_back.sv */
// ----------------------------------------------------------------------------
// agf_back
// Likelihood back end: log by repeated squaring, bit-serial divide,
// saturating term sum and series mean, output register.
// ----------------------------------------------------------------------------
`include "arma_garch_likelihood_filter_macros.svh"

module agf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  agf_pkg::agf_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output agf_pkg::agf_rsp_type  rsp_data
);
   import agf_pkg::*;

   agf_back_state_type state_ff, state_in;

   agf_item_type       it_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        num_ff, quo_ff;
   logic [32:0]        rem_ff;
   logic [31:0]        div_ff;
   logic [5:0]         cnt_ff;
   logic [31:0]        x_ff, frac_ff;
   logic [4:0]         k_ff;
   logic [32:0]        lnf_ff;
   logic signed [47:0] sum_ff;
   logic signed [31:0] term_ff, mean_ff;
   agf_rsp_type        out_ff;
   logic               out_valid_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [32:0]        rem_sh, rem_sub;
   logic               take;
   logic [32:0]        sq_y;
   logic signed [5:0]  sk;
   logic signed [40:0] l32, lnq;
   logic [47:0]        qcl;
   logic signed [49:0] tsum;
   logic signed [48:0] acc_sum;
   logic signed [47:0] sum_sat;
   logic [47:0]        mag;
   logic [48:0]        mean_q;
   logic signed [63:0] mean_s;
   logic               out_free;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   // Multiplier operand select
   assign sk = $signed({1'b0, k_ff}) - 6'(FRAC_BITS);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_ESQ: begin
            mul_a = 33'(it_ff.residual);
            mul_b = 33'(it_ff.residual);
         end
         B_SQMUL: begin
            mul_a = $signed({1'b0, x_ff});
            mul_b = $signed({1'b0, x_ff});
         end
         B_LNA: begin
            mul_a = $signed({1'b0, frac_ff});
            mul_b = $signed({1'b0, LN2_Q32});
         end
         B_LNB: begin
            mul_a = 33'(sk);
            mul_b = $signed({1'b0, LN2_Q32});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // One restoring divide step
   assign rem_sh  = {rem_ff[31:0], num_ff[63]};
   assign take    = rem_sh >= {1'b0, div_ff};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   // Squaring step and log assembly
   assign sq_y    = prod_ff[63:31];
   assign l32     = $signed(prod_ff[40:0]) + $signed({8'b0, lnf_ff});
   assign lnq     = (l32 + (41'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
   assign qcl     = (quo_ff > 64'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : quo_ff[47:0];
   assign tsum    = 50'(lnq) + $signed({2'b0, qcl});

   // Saturating accumulate
   assign acc_sum = 49'(sum_ff) + 49'(term_ff);
   always_comb begin
      if (acc_sum > 49'sh07FFFFFFFFFFF)
         sum_sat = 48'sh7FFFFFFFFFFF;
      else if (acc_sum < -49'sh0800000000000)
         sum_sat = 48'sh800000000000;
      else
         sum_sat = acc_sum[47:0];
   end

   // Mean, rounded half away from zero
   assign mag    = sum_ff[47] ? 48'(-sum_ff) : 48'(sum_ff);
   assign mean_q = quo_ff[48:0];
   assign mean_s = sum_ff[47] ? -$signed({15'b0, mean_q}) : $signed({15'b0, mean_q});

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!q_empty) begin
            if (!q_item.add)
               state_in = B_OUT;
            else if (q_item.variance == 32'd0)
               state_in = B_ACC;
            else
               state_in = B_ESQ;
         end
         B_ESQ:   state_in = B_NUM;
         B_NUM:   state_in = B_DIV;
         B_DIV:   if (cnt_ff == 6'd63) state_in = B_NORM;
         B_NORM:  if (x_ff[31]) state_in = B_SQMUL;
         B_SQMUL: state_in = B_SQADJ;
         B_SQADJ: state_in = (cnt_ff == 6'd31) ? B_LNA : B_SQMUL;
         B_LNA:   state_in = B_LNB;
         B_LNB:   state_in = B_LNC;
         B_LNC:   state_in = B_ACC;
         B_ACC:   state_in = it_ff.last ? B_MEAN : B_OUT;
         B_MEAN:  state_in = B_MDIV;
         B_MDIV:  if (cnt_ff == 6'd63) state_in = B_MFIN;
         B_MFIN:  state_in = B_OUT;
         B_OUT:   if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         B_IDLE: if (!q_empty) begin
            it_ff   <= q_item;
            term_ff <= '0;
            mean_ff <= '0;
         end
         B_NUM: begin
            num_ff <= {prod_ff[62:0], 1'b0} + 64'(it_ff.variance >> 1);
            div_ff <= it_ff.variance;
            rem_ff <= '0;
            cnt_ff <= '0;
            x_ff   <= it_ff.variance;
            k_ff   <= 5'd31;
         end
         B_DIV, B_MDIV: begin
            rem_ff <= take ? rem_sub : rem_sh;
            quo_ff <= {quo_ff[62:0], take};
            num_ff <= {num_ff[62:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
         end
         B_NORM: begin
            cnt_ff <= '0;
            if (!x_ff[31]) begin
               x_ff <= {x_ff[30:0], 1'b0};
               k_ff <= k_ff - 5'd1;
            end
         end
         B_SQADJ: begin
            frac_ff <= {frac_ff[30:0], sq_y[32]};
            x_ff    <= sq_y[32] ? sq_y[32:1] : sq_y[31:0];
            cnt_ff  <= cnt_ff + 6'd1;
         end
         B_LNB: lnf_ff <= 33'((prod_ff[64:0] + 65'h80000000) >> 32);
         B_LNC: term_ff <= agf_sat32(64'(tsum));
         B_MEAN: begin
            num_ff <= 64'(mag) + 64'(it_ff.count >> 1);
            div_ff <= 32'(it_ff.count);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         B_MFIN: mean_ff <= agf_sat32(mean_s);
         default: begin
         end
      endcase
   end

   // Series sum: clear on a conditioning transaction, add each term
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (q_pop && q_item.cond) begin
         sum_ff <= '0;
      end else if (state_ff == B_ACC) begin
         sum_ff <= sum_sat;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == B_OUT && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_OUT && out_free) begin
         out_ff.residual <= it_ff.residual;
         out_ff.variance <= it_ff.variance;
         out_ff.nll_term <= term_ff;
         out_ff.mean_nll <= mean_ff;
         out_ff.failed   <= it_ff.failed;
         out_ff.last_out <= it_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `AGF_ASSERT_IMPL(a_fail_no_term, rsp_valid && rsp_data.failed, rsp_data.nll_term == 32'sd0)
   `AGF_ASSERT_IMPL(a_mean_on_last, rsp_valid && (rsp_data.mean_nll != 32'sd0), rsp_data.last_out && !rsp_data.failed)
   `AGF_ASSERT_IMPL(a_mean_divisor, state_ff == B_MDIV, it_ff.count != '0)
   `AGF_ASSERT(a_div_nonzero, (state_ff != B_DIV) || (div_ff != 32'd0))

endmodule
